FILE: hw/rtl/jwi_pkg.sv
// Shared types, codes and default sizes for the joint waypoint interpolator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package jwi_pkg;

  localparam int MAX_POINTS_DEF    = 64;
  localparam int NUM_JOINTS_DEF    = 6;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int TIME_W      = 32;
  localparam int ANGLE_W     = 20;
  localparam int PORT_JOINTS = 6;
  localparam int JIDX_W      = 3;

  // Shared multiplier: magnitude operand by constant or fraction operand
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // round(180000/pi * 2^16), radians Q3.16 to millidegrees in Q32
  localparam logic [MUL_B_W-1:0] RAD_TO_MDEG_Q32 = 32'd3754936206;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [TIME_W-1:0]         time_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_MUL,
    S_APP_WR,
    S_Q_LAST,
    S_Q_FIRST,
    S_Q_SCAN,
    S_Q_DIV,
    S_B_RD0,
    S_B_RD1,
    S_B_MUL,
    S_B_ACC,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/jwi_if.sv
// Request and result channel interfaces of the joint waypoint interpolator.
// Depends on jwi_pkg for the payload types.
`default_nettype none

interface jwi_in_if;
  import jwi_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  time_t  time_value;
  angle_t joint_0;
  angle_t joint_1;
  angle_t joint_2;
  angle_t joint_3;
  angle_t joint_4;
  angle_t joint_5;

  modport source (
    output valid, command, time_value,
    output joint_0, joint_1, joint_2, joint_3, joint_4, joint_5,
    input  ready
  );

  modport sink (
    input  valid, command, time_value,
    input  joint_0, joint_1, joint_2, joint_3, joint_4, joint_5,
    output ready
  );
endinterface

interface jwi_out_if;
  import jwi_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    at_end;
  angle_t  target_0;
  angle_t  target_1;
  angle_t  target_2;
  angle_t  target_3;
  angle_t  target_4;
  angle_t  target_5;

  modport source (
    output valid, status, at_end,
    output target_0, target_1, target_2, target_3, target_4, target_5,
    input  ready
  );

  modport sink (
    input  valid, status, at_end,
    input  target_0, target_1, target_2, target_3, target_4, target_5,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/joint_waypoint_interpolator_unit.sv
// Joint waypoint interpolator: waypoint table, sequencer and shared datapath.
// Depends on jwi_pkg and the channel interfaces in jwi_if.sv.
//
// Usage: requests arrive on in_chan (valid/ready). command CLEAR empties the
// table, APPEND converts joint_0..5 from radians Q3.16 to millidegrees and
// stores them with time_value, QUERY returns the piecewise linear position
// at time_value on out_chan together with status and at_end. Every request
// produces exactly one result.
// One request is worked on at a time; in_chan.ready is high only while the
// sequencer is idle. The work between acceptance and a valid result:
//   clear, dropped append, empty query, no-op: straight to the done state
//   append: one pass of the shared multiplier per joint, then its write
//   query:  reads of the last and first timestamps; unless the time is at
//           or beyond either end, a scan of the timestamps at one entry per
//           cycle and, unless an entry matches, the bit-serial fraction
//           divider; then, per joint, two reads, a multiply and an accumulate.
// Reset empties the table and drops any pending result. A finished result
// waits in the output register while out_chan.ready is low; the next
// request can be accepted then, but its result holds in the sequencer until
// the output register frees.
`default_nettype none

module joint_waypoint_interpolator_unit #(
  parameter int MAX_POINTS    = jwi_pkg::MAX_POINTS_DEF,
  parameter int NUM_JOINTS    = jwi_pkg::NUM_JOINTS_DEF,
  parameter int FRACTION_BITS = jwi_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  jwi_in_if.sink    in_chan,
  jwi_out_if.source out_chan
);
  import jwi_pkg::*;

  localparam int PW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int ADEPTH = MAX_POINTS * NUM_JOINTS;
  localparam int AAW    = $clog2(ADEPTH);
  localparam int AW     = FRACTION_BITS + 1;
  localparam int DCW    = $clog2(FRACTION_BITS);
  localparam int QW     = MUL_A_W;

  localparam logic [MUL_P_W-1:0] BLEND_HALF = MUL_P_W'(1) << (FRACTION_BITS - 1);
  localparam logic [MUL_P_W-1:0] CONV_HALF  = MUL_P_W'(1) << (MUL_B_W - 1);
  localparam logic [AW-1:0]      FULL_ALPHA = AW'(1) << FRACTION_BITS;
  localparam logic [JIDX_W-1:0]  LAST_J     = JIDX_W'(NUM_JOINTS - 1);
  localparam logic [DCW-1:0]     LAST_DIV   = DCW'(FRACTION_BITS - 1);
  localparam logic [CW-1:0]      CNT_MAX    = CW'(MAX_POINTS);
  localparam logic [CW-1:0]      CNT_ONE    = CW'(1);

  function automatic logic [AAW-1:0] ang_addr(input logic [PW-1:0] pt,
                                              input logic [JIDX_W-1:0] j);
    return AAW'(int'(pt) * NUM_JOINTS + int'(j));
  endfunction

  // Memories
  time_t  time_mem [MAX_POINTS];
  angle_t ang_mem  [ADEPTH];

  logic             t_we;
  logic [PW-1:0]    t_waddr;
  logic [PW-1:0]    t_raddr;
  time_t            t_rdata_r;
  logic             a_we;
  logic [AAW-1:0]   a_waddr;
  angle_t           a_wdata;
  logic [AAW-1:0]   a_raddr;
  angle_t           a_rdata_r;

  // Control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working registers
  time_t            t_r;
  angle_t           jin_r [PORT_JOINTS];
  angle_t           res_r [PORT_JOINTS];
  angle_t           res_nxt [PORT_JOINTS];
  status_t          status_r, status_nxt;
  logic             at_end_r, at_end_nxt;
  logic [JIDX_W-1:0] jidx_r, jidx_nxt;
  logic [PW-1:0]    pt0_r, pt0_nxt;
  logic [PW-1:0]    pt1_r, pt1_nxt;
  logic [PW-1:0]    scan_r, scan_nxt;
  time_t            prev_r, prev_nxt;
  time_t            den_r, den_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [AW-1:0]    alpha_r, alpha_nxt;
  logic [DCW-1:0]   div_cnt_r, div_cnt_nxt;
  angle_t           a0_r, a0_nxt;
  logic             neg_r, neg_nxt;
  logic [MUL_P_W-1:0] prod_r;

  // Output registers
  status_t          out_status_r;
  logic             out_at_end_r;
  angle_t           out_tgt_r [PORT_JOINTS];
  logic             out_load;

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // Decoded conditions
  cmd_t             in_cmd;
  angle_t           in_joints [PORT_JOINTS];
  logic             accept;
  logic             table_full;
  logic             table_empty;
  logic             last_j;
  logic [PW-1:0]    last_pt;
  logic             first_pt;
  logic             scan_hit;

  // Datapath helpers
  angle_t             jsel;
  logic [ANGLE_W-1:0] jmag;
  logic signed [ANGLE_W:0] diff;
  logic [MUL_A_W-1:0] dmag;
  logic [MUL_P_W-1:0] conv_sum;
  logic [ANGLE_W-1:0] conv_q;
  angle_t             conv_res;
  logic [MUL_P_W-1:0] blend_sum;
  logic [QW-1:0]      blend_q;
  logic signed [ANGLE_W+1:0] blend_wide;
  logic [TIME_W:0]    div_shl;
  logic [TIME_W:0]    div_sub;
  logic               div_ge;

  assign in_cmd       = in_chan.command;
  assign in_joints[0] = in_chan.joint_0;
  assign in_joints[1] = in_chan.joint_1;
  assign in_joints[2] = in_chan.joint_2;
  assign in_joints[3] = in_chan.joint_3;
  assign in_joints[4] = in_chan.joint_4;
  assign in_joints[5] = in_chan.joint_5;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign table_full    = (count_r >= CNT_MAX);
  assign table_empty   = (count_r == '0);
  assign last_j        = (jidx_r == LAST_J);
  assign last_pt       = PW'(count_r - CNT_ONE);
  assign first_pt      = (count_r == CNT_ONE) || (t_r <= t_rdata_r);
  assign scan_hit      = (t_rdata_r >= t_r);
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Angle conversion: magnitude times constant, round half up, restore sign
  assign jsel     = jin_r[jidx_r];
  assign jmag     = jsel[ANGLE_W-1] ? ANGLE_W'(-jsel) : ANGLE_W'(jsel);
  assign conv_sum = prod_r + CONV_HALF;
  assign conv_q   = conv_sum[MUL_B_W +: ANGLE_W];
  assign conv_res = neg_r ? angle_t'(-conv_q) : angle_t'(conv_q);

  // Blend: a0 +/- round(|a1 - a0| * alpha)
  assign diff       = {a_rdata_r[ANGLE_W-1], a_rdata_r} - {a0_r[ANGLE_W-1], a0_r};
  assign dmag       = diff[ANGLE_W] ? MUL_A_W'(-diff) : MUL_A_W'(diff);
  assign blend_sum  = prod_r + BLEND_HALF;
  assign blend_q    = blend_sum[FRACTION_BITS +: QW];
  assign blend_wide = neg_r ? ({{2{a0_r[ANGLE_W-1]}}, a0_r} - {1'b0, blend_q})
                            : ({{2{a0_r[ANGLE_W-1]}}, a0_r} + {1'b0, blend_q});

  // One restoring division step; the remainder always stays below the divisor
  assign div_shl = {rem_r, 1'b0};
  assign div_sub = div_shl - {1'b0, den_r};
  assign div_ge  = (div_shl >= {1'b0, den_r});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_APPEND: state_nxt = table_full ? S_DONE : S_APP_MUL;
            CMD_QUERY:  state_nxt = table_empty ? S_DONE : S_Q_LAST;
            CMD_CLEAR,
            CMD_NOP:    state_nxt = S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_APP_MUL: state_nxt = S_APP_WR;
      S_APP_WR:  state_nxt = last_j ? S_DONE : S_APP_MUL;
      S_Q_LAST:  state_nxt = S_Q_FIRST;
      S_Q_FIRST: state_nxt = (first_pt || at_end_r) ? S_B_RD0 : S_Q_SCAN;
      S_Q_SCAN: begin
        if (scan_hit) begin
          state_nxt = (t_rdata_r == t_r) ? S_B_RD0 : S_Q_DIV;
        end
      end
      S_Q_DIV:   state_nxt = (div_cnt_r == LAST_DIV) ? S_B_RD0 : S_Q_DIV;
      S_B_RD0:   state_nxt = S_B_RD1;
      S_B_RD1:   state_nxt = S_B_MUL;
      S_B_MUL:   state_nxt = S_B_ACC;
      S_B_ACC:   state_nxt = last_j ? S_DONE : S_B_RD0;
      S_DONE:    state_nxt = out_load ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    count_nxt   = count_r;
    res_nxt     = res_r;
    status_nxt  = status_r;
    at_end_nxt  = at_end_r;
    jidx_nxt    = jidx_r;
    pt0_nxt     = pt0_r;
    pt1_nxt     = pt1_r;
    scan_nxt    = scan_r;
    prev_nxt    = prev_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    alpha_nxt   = alpha_r;
    div_cnt_nxt = div_cnt_r;
    a0_nxt      = a0_r;
    neg_nxt     = neg_r;
    mul_a       = '0;
    mul_b       = '0;
    t_we        = 1'b0;
    t_waddr     = PW'(count_r);
    t_raddr     = '0;
    a_we        = 1'b0;
    a_waddr     = ang_addr(PW'(count_r), jidx_r);
    a_wdata     = conv_res;
    a_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        t_raddr = last_pt;
        if (accept) begin
          for (int k = 0; k < PORT_JOINTS; k++) begin
            res_nxt[k] = '0;
          end
          status_nxt = STAT_OK;
          at_end_nxt = 1'b0;
          jidx_nxt   = '0;
          unique case (in_cmd)
            CMD_CLEAR: count_nxt = '0;
            CMD_APPEND: begin
              if (table_full) begin
                status_nxt = STAT_FULL;
              end else begin
                t_we = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (table_empty) begin
                status_nxt = STAT_EMPTY;
              end
            end
            CMD_NOP: ;
            default: ;
          endcase
        end
      end
      S_APP_MUL: begin
        mul_a   = MUL_A_W'(jmag);
        mul_b   = RAD_TO_MDEG_Q32;
        neg_nxt = jsel[ANGLE_W-1];
      end
      S_APP_WR: begin
        a_we = 1'b1;
        if (last_j) begin
          count_nxt = count_r + CNT_ONE;
        end else begin
          jidx_nxt = jidx_r + JIDX_W'(1);
        end
      end
      S_Q_LAST: begin
        at_end_nxt = (t_r >= t_rdata_r);
        t_raddr    = '0;
      end
      S_Q_FIRST: begin
        alpha_nxt = '0;
        if (first_pt) begin
          pt0_nxt = '0;
          pt1_nxt = '0;
        end else if (at_end_r) begin
          pt0_nxt = last_pt;
          pt1_nxt = last_pt;
        end else begin
          prev_nxt = t_rdata_r;
          scan_nxt = PW'(1);
          t_raddr  = PW'(1);
        end
      end
      S_Q_SCAN: begin
        // keep one read in flight: address scan+1 while comparing entry scan
        t_raddr = scan_r + PW'(1);
        if (scan_hit) begin
          pt0_nxt     = scan_r - PW'(1);
          pt1_nxt     = scan_r;
          den_nxt     = t_rdata_r - prev_r;
          rem_nxt     = t_r - prev_r;
          div_cnt_nxt = '0;
          alpha_nxt   = (t_rdata_r == t_r) ? FULL_ALPHA : '0;
        end else begin
          prev_nxt = t_rdata_r;
          scan_nxt = scan_r + PW'(1);
        end
      end
      S_Q_DIV: begin
        rem_nxt     = div_ge ? div_sub[TIME_W-1:0] : div_shl[TIME_W-1:0];
        alpha_nxt   = {alpha_r[AW-2:0], div_ge};
        div_cnt_nxt = div_cnt_r + DCW'(1);
      end
      S_B_RD0: a_raddr = ang_addr(pt0_r, jidx_r);
      S_B_RD1: begin
        a0_nxt  = a_rdata_r;
        a_raddr = ang_addr(pt1_r, jidx_r);
      end
      S_B_MUL: begin
        mul_a   = dmag;
        mul_b   = MUL_B_W'(alpha_r);
        neg_nxt = diff[ANGLE_W];
      end
      S_B_ACC: begin
        res_nxt[jidx_r] = angle_t'(blend_wide[ANGLE_W-1:0]);
        if (!last_j) begin
          jidx_nxt = jidx_r + JIDX_W'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_r   <= in_chan.time_value;
      jin_r <= in_joints;
    end
    res_r     <= res_nxt;
    status_r  <= status_nxt;
    at_end_r  <= at_end_nxt;
    jidx_r    <= jidx_nxt;
    pt0_r     <= pt0_nxt;
    pt1_r     <= pt1_nxt;
    scan_r    <= scan_nxt;
    prev_r    <= prev_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    alpha_r   <= alpha_nxt;
    div_cnt_r <= div_cnt_nxt;
    a0_r      <= a0_nxt;
    neg_r     <= neg_nxt;
    prod_r    <= mul_p;
    if (out_load) begin
      out_status_r <= status_r;
      out_at_end_r <= at_end_r;
      out_tgt_r    <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      time_mem[t_waddr] <= in_chan.time_value;
    end
    t_rdata_r <= time_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      ang_mem[a_waddr] <= a_wdata;
    end
    a_rdata_r <= ang_mem[a_raddr];
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.at_end   = out_at_end_r;
  assign out_chan.target_0 = out_tgt_r[0];
  assign out_chan.target_1 = out_tgt_r[1];
  assign out_chan.target_2 = out_tgt_r[2];
  assign out_chan.target_3 = out_tgt_r[3];
  assign out_chan.target_4 = out_tgt_r[4];
  assign out_chan.target_5 = out_tgt_r[5];

endmodule

`default_nettype wire

FILE: hw/rtl/jwi_checker.sv
// Port-level checks for joint_waypoint_interpolator_unit and the bind that
// attaches them. Depends on jwi_pkg and the top level's channel interfaces.
`default_nettype none

module jwi_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input jwi_pkg::status_t status,
  input logic             at_end,
  input jwi_pkg::angle_t  target_0,
  input jwi_pkg::angle_t  target_1,
  input jwi_pkg::angle_t  target_2,
  input jwi_pkg::angle_t  target_3,
  input jwi_pkg::angle_t  target_4,
  input jwi_pkg::angle_t  target_5
);
  import jwi_pkg::*;

  logic targets_zero;

  assign targets_zero = (target_0 == '0) && (target_1 == '0) && (target_2 == '0) &&
                        (target_3 == '0) && (target_4 == '0) && (target_5 == '0);

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // Every request leaves the idle state, so ready drops after an accept
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted back to back");

  // A stalled result holds (status, at_end, target_0 and target_5 are checked)
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(at_end) &&
                                $stable(target_0) && $stable(target_5))
    else $error("stalled result changed");

  // Dropped append and empty query carry no position
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_FULL || status == STAT_EMPTY) |-> !at_end && targets_zero)
    else $error("error result carries position data");

  a_at_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && at_end |-> status == STAT_OK)
    else $error("at_end set on an error result");

endmodule

bind joint_waypoint_interpolator_unit jwi_checker u_jwi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .status    (out_chan.status),
  .at_end    (out_chan.at_end),
  .target_0  (out_chan.target_0),
  .target_1  (out_chan.target_1),
  .target_2  (out_chan.target_2),
  .target_3  (out_chan.target_3),
  .target_4  (out_chan.target_4),
  .target_5  (out_chan.target_5)
);

`default_nettype wire
